// ===== rtl/pse_pkg.sv =====
// Shared types and constants for the prime sieve engine.
package pse_pkg;

    localparam int LIMIT_W  = 13;  // sieve_limit register width
    localparam int NUM_W    = 12;  // query number width
    localparam int STATUS_W = 2;
    localparam int ROOT_W   = 7;   // outer index, i*i never passes 8281
    localparam int CNT_W    = 14;  // fill / strike counter, holds j + i

    localparam logic [ROOT_W-1:0] FIRST_PRIME = ROOT_W'(2);

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNBUILT = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd1000;

    // Requests from the top level to the sieve core
    typedef struct packed {
        logic             build;
        logic             query;
        logic [NUM_W-1:0] number;
    } t_core_req;

    // Core status back to the top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

endpackage

// ===== rtl/pse_if.sv =====
// Handshake channel interfaces for the prime sieve engine.
interface pse_in_if;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [pse_pkg::NUM_W-1:0] number;

    modport source (output valid, output op, output number, input ready);
    modport sink   (input valid, input op, input number, output ready);
endinterface

interface pse_out_if;
    logic                        valid;
    logic                        ready;
    logic                        is_prime;
    logic [pse_pkg::STATUS_W-1:0] status;

    modport source (output valid, output is_prime, output status, input ready);
    modport sink   (input valid, input is_prime, input status, output ready);
endinterface

interface pse_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [pse_pkg::LIMIT_W-1:0] sieve_limit;

    modport source (output valid, output sieve_limit, input ready);
    modport sink   (input valid, input sieve_limit, output ready);
endinterface

// ===== rtl/prime_sieve_engine_unit.sv =====
// Top level of the prime sieve engine: channels, limit register, result staging.
// Usage
//   i_in  : words carrying op (build or query) and a 12-bit number.
//   o_out : one word per input word, is_prime and status.
//   i_cfg : writes sieve_limit; always ready. A write also drops the
//           built flag, so queries report "not built" until the next build.
// Flow and throughput
//   Query : read issued at the accepting edge, which also loads the staging
//           register; the word moves to o_out once o_out is free. One query a
//           cycle when the receiver keeps up (single read port of the store).
//   Build : fills every entry below lim, then reads and checks each outer
//           index; a prime one strikes each multiple from i*i, then closes
//           the run. A last read state ends it. No words are taken meanwhile.
// Reset
//   Synchronous, active low: limit back to 1000, built flag and handshake
//   state cleared. The store is not cleared; a build writes every entry
//   that a later query may read.
// Back-pressure
//   A held result waits in o_out, one more in the staging stage; i_in
//   drops ready once both are full.
module prime_sieve_engine_unit #(
    parameter int MAX_NUMBERS = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pse_in_if.sink        i_in,
    pse_out_if.source     o_out,
    pse_cfg_if.sink       i_cfg
);

    // largest effective limit the register can reach with this store
    localparam int LIM_CAP = (MAX_NUMBERS > 8191) ? 8191 : MAX_NUMBERS;
    localparam logic [pse_pkg::LIMIT_W-1:0] LIM_CAP_V = pse_pkg::LIMIT_W'(LIM_CAP);

    logic [pse_pkg::LIMIT_W-1:0]  r_limit;
    logic                         r_built;
    logic [pse_pkg::LIMIT_W-1:0]  lim;

    // staging stage: holds a result whose prime bit may come from the store
    logic                         r_q_vld;
    logic                         r_q_use_mem;
    logic [pse_pkg::STATUS_W-1:0] r_q_status;

    logic                         r_out_vld;
    logic                         r_out_prime;
    logic [pse_pkg::STATUS_W-1:0] r_out_status;

    pse_pkg::t_core_req           req;
    pse_pkg::t_core_stat          stat;
    logic                         rd_bit;
    logic                         q_move, in_acc, cfg_acc;
    logic [pse_pkg::STATUS_W-1:0] q_status;

    assign lim = (r_limit > LIM_CAP_V) ? LIM_CAP_V : r_limit;

    assign q_move      = r_q_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !stat.busy && (!r_q_vld || q_move);
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid;

    assign req.build  = in_acc && (i_in.op == pse_pkg::OP_BUILD);
    assign req.query  = in_acc && (i_in.op == pse_pkg::OP_QUERY);
    assign req.number = i_in.number;

    always_comb begin
        if (!r_built) begin
            q_status = pse_pkg::STATUS_UNBUILT;
        end else if (pse_pkg::LIMIT_W'(i_in.number) >= lim) begin
            q_status = pse_pkg::STATUS_RANGE;
        end else begin
            q_status = pse_pkg::STATUS_OK;
        end
    end

    pse_core #(
        .MAX_NUMBERS (MAX_NUMBERS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_limit  (lim),
        .o_stat   (stat),
        .o_rd_bit (rd_bit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= pse_pkg::LIMIT_RESET;
            r_built   <= 1'b0;
            r_q_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (cfg_acc) begin
                r_limit <= i_cfg.sieve_limit;
                r_built <= 1'b0;
            end else if (stat.done) begin
                r_built <= 1'b1;
            end

            // staging stage fills on a query or at the end of a build
            if (req.query || stat.done) begin
                r_q_vld <= 1'b1;
            end else if (q_move) begin
                r_q_vld <= 1'b0;
            end

            if (q_move) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req.query) begin
            r_q_use_mem <= (q_status == pse_pkg::STATUS_OK);
            r_q_status  <= q_status;
        end else if (stat.done) begin
            r_q_use_mem <= 1'b0;
            r_q_status  <= pse_pkg::STATUS_OK;
        end
        if (q_move) begin
            r_out_prime  <= r_q_use_mem & rd_bit;
            r_out_status <= r_q_status;
        end
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.is_prime = r_out_prime;
    assign o_out.status   = r_out_status;

endmodule

// ===== rtl/pse_core.sv =====
// Primality store and the build sequencer that sieves it.
module pse_core #(
    parameter int MAX_NUMBERS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pse_pkg::t_core_req            i_req,
    input  logic [pse_pkg::LIMIT_W-1:0]   i_limit,
    output pse_pkg::t_core_stat           o_stat,
    output logic                          o_rd_bit
);

    localparam int ADDR_W = $clog2(MAX_NUMBERS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FILL = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_CLR  = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [pse_pkg::ROOT_W-1:0]   r_i, n_i;
    logic [pse_pkg::CNT_W-1:0]    r_j, n_j;

    logic                         mem [MAX_NUMBERS];
    logic                         r_rd;
    logic                         we, wdata, re, done;
    logic [ADDR_W-1:0]            waddr, raddr;
    logic [pse_pkg::CNT_W-1:0]    sq, lim_ext;
    logic                         j_in;

    assign lim_ext = pse_pkg::CNT_W'(i_limit);
    assign sq      = pse_pkg::CNT_W'(r_i) * pse_pkg::CNT_W'(r_i);
    assign j_in    = (r_j < lim_ext);

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        we      = 1'b0;
        wdata   = 1'b0;
        waddr   = ADDR_W'(r_j);
        re      = 1'b0;
        raddr   = ADDR_W'(i_req.number);
        done    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_req.build) begin
                    n_j     = '0;
                    n_state = ST_FILL;
                end else if (i_req.query) begin
                    re = 1'b1;
                end
            end
            ST_FILL: begin
                // mark 2 .. lim-1 prime, 0 and 1 not
                if (j_in) begin
                    we    = 1'b1;
                    wdata = (r_j >= pse_pkg::CNT_W'(pse_pkg::FIRST_PRIME));
                    n_j   = r_j + pse_pkg::CNT_W'(1);
                end else begin
                    n_i     = pse_pkg::FIRST_PRIME;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                if (sq < lim_ext) begin
                    re      = 1'b1;
                    raddr   = ADDR_W'(r_i);
                    n_state = ST_CHK;
                end else begin
                    done    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_CHK: begin
                if (r_rd) begin
                    n_j     = sq;
                    n_state = ST_CLR;
                end else begin
                    n_i     = r_i + pse_pkg::ROOT_W'(1);
                    n_state = ST_RD;
                end
            end
            ST_CLR: begin
                if (j_in) begin
                    we  = 1'b1;
                    n_j = r_j + pse_pkg::CNT_W'(r_i);
                end else begin
                    n_i     = r_i + pse_pkg::ROOT_W'(1);
                    n_state = ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i <= n_i;
        r_j <= n_j;
    end

    // one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd <= mem[raddr];
        end
    end

    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.done = done;
    assign o_rd_bit    = r_rd;

endmodule

// ===== bench/pse_checker.sv =====
`timescale 1ns / 1ps
// Watches the sieve engine's channels, predicts each result and compares it.
module pse_checker #(
    parameter int MAX_NUMBERS = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pse_in_if    in_ch,
    pse_out_if   out_ch,
    pse_cfg_if   cfg_ch,
    input  logic i_run_end,
    output int   o_fail_count
);

    typedef struct {
        logic                         op;
        logic [pse_pkg::NUM_W-1:0]    number;
        logic                         is_prime;
        logic [pse_pkg::STATUS_W-1:0] status;
    } t_verdict;

    bit                          sieve_map [MAX_NUMBERS];
    bit                          map_built;
    logic [pse_pkg::LIMIT_W-1:0] limit_reg;
    t_verdict                    verdict_q [$];
    int                          fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic predict_word(input logic op, input logic [pse_pkg::NUM_W-1:0] num);
        t_verdict    v;
        int unsigned span;
        v.op       = op;
        v.number   = num;
        v.is_prime = 1'b0;
        v.status   = pse_pkg::STATUS_OK;
        span = (limit_reg > MAX_NUMBERS) ? MAX_NUMBERS : limit_reg;
        if (op == pse_pkg::OP_BUILD) begin
            for (int unsigned k = 0; k < span; k++)
                sieve_map[k] = (k >= 2);
            for (int unsigned i = 2; i * i < span; i++) begin
                if (sieve_map[i]) begin
                    for (int unsigned j = i * i; j < span; j += i)
                        sieve_map[j] = 1'b0;
                end
            end
            map_built = 1'b1;
        end else if (!map_built) begin
            v.status = pse_pkg::STATUS_UNBUILT;
        end else if (num >= span) begin
            v.status = pse_pkg::STATUS_RANGE;
        end else begin
            v.is_prime = sieve_map[num];
        end
        verdict_q.push_back(v);
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            limit_reg = pse_pkg::LIMIT_RESET;
            map_built = 1'b0;
            verdict_q.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                limit_reg = cfg_ch.sieve_limit;
                map_built = 1'b0;
            end
            if (in_ch.valid && in_ch.ready)
                predict_word(in_ch.op, in_ch.number);
            if (out_ch.valid && out_ch.ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("word is_prime=%0b status=%0d, none expected",
                                              out_ch.is_prime, out_ch.status));
                end else begin
                    want = verdict_q.pop_front();
                    if (out_ch.is_prime !== want.is_prime)
                        report_mismatch($sformatf("op=%0b num=%0d is_prime %0b, want %0b",
                                                  want.op, want.number,
                                                  out_ch.is_prime, want.is_prime));
                    if (out_ch.status !== want.status)
                        report_mismatch($sformatf("op=%0b num=%0d status %0d, want %0d",
                                                  want.op, want.number,
                                                  out_ch.status, want.status));
                end
            end
        end
    end

    always @(posedge i_run_end) begin
        if (verdict_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Bench top for the prime sieve engine: clock, reset, stimulus and verdict.
module tb_top;

    localparam int MAP_DEPTH   = 4096;
    // a handful of full 4096 builds plus ~1000 stalled words is far below this
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 77;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int cycle_count = 0;
    int words_sent  = 0;
    int words_back  = 0;
    int chk_fail;
    bit idle_on = 1'b1;     // random gaps on both sides
    bit hold_req;           // stimulus asks the sink for a long hold-off
    bit run_end;

    pse_in_if  in_ch ();
    pse_out_if out_ch ();
    pse_cfg_if cfg_ch ();

    prime_sieve_engine_unit #(
        .MAX_NUMBERS(MAP_DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    pse_checker #(
        .MAX_NUMBERS(MAP_DEPTH)
    ) u_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_ch      (cfg_ch),
        .i_run_end   (run_end),
        .o_fail_count(chk_fail)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result sink. Ready drops at random (~6%), or for a long stretch when
    // asked, so the staging stage and o_out both fill and i_in stalls.
    initial begin : result_sink
        int hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                words_back++;
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(idle_on && $urandom_range(99) < 6);
            end
        end
    end

    // Offer one word; valid stays high after acceptance so back-to-back
    // words need no second assignment in the same step.
    task automatic send_word(input logic op, input logic [pse_pkg::NUM_W-1:0] num);
        while (idle_on && $urandom_range(99) < 6) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.op     <= op;
        in_ch.number <= num;
        do @(posedge clk); while (!in_ch.ready);
        words_sent++;
    endtask

    // Stop offering and wait until every word has its result back.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (words_back != words_sent) @(posedge clk);
    endtask

    // Limit write; only ever issued with the engine idle, and always
    // followed by at least one word before the next write.
    task automatic write_limit(input logic [pse_pkg::LIMIT_W-1:0] value);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.sieve_limit <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned probes [9] = '{0, 1, 2, 3, 4, 997, 999, 1000, 4095};
        int unsigned lim;
        int unsigned span;
        int unsigned num;
        int unsigned roll;

        in_ch.valid        = 1'b0;
        in_ch.op           = pse_pkg::OP_QUERY;
        in_ch.number       = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.sieve_limit = pse_pkg::LIMIT_RESET;
        run_end            = 1'b0;
        hold_req           = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // reset limit of 1000; a query ahead of any build is "not built"
        send_word(pse_pkg::OP_QUERY, pse_pkg::NUM_W'(5));
        send_word(pse_pkg::OP_BUILD, '1);
        // 0 and 1 non-prime, small primes, 997 prime, 999 composite,
        // limit itself and the top number out of range
        foreach (probes[k])
            send_word(pse_pkg::OP_QUERY, pse_pkg::NUM_W'(probes[k]));

        // limit 0: the build marks nothing, every query is out of range
        wait_idle();
        write_limit('0);
        send_word(pse_pkg::OP_BUILD, '0);
        send_word(pse_pkg::OP_QUERY, pse_pkg::NUM_W'(0));
        send_word(pse_pkg::OP_QUERY, pse_pkg::NUM_W'(1));

        // limit 1: the write drops the built flag first
        wait_idle();
        write_limit(pse_pkg::LIMIT_W'(1));
        send_word(pse_pkg::OP_QUERY, pse_pkg::NUM_W'(0));
        send_word(pse_pkg::OP_BUILD, pse_pkg::NUM_W'(1));
        send_word(pse_pkg::OP_QUERY, pse_pkg::NUM_W'(0));

        // limit 2: only 0 and 1 covered, both non-prime
        wait_idle();
        write_limit(pse_pkg::LIMIT_W'(2));
        send_word(pse_pkg::OP_BUILD, pse_pkg::NUM_W'(2));
        send_word(pse_pkg::OP_QUERY, pse_pkg::NUM_W'(0));
        send_word(pse_pkg::OP_QUERY, pse_pkg::NUM_W'(1));

        // all-ones limit saturates at the store depth
        wait_idle();
        write_limit('1);
        send_word(pse_pkg::OP_BUILD, pse_pkg::NUM_W'(3));
        send_word(pse_pkg::OP_QUERY, pse_pkg::NUM_W'(4095));
        send_word(pse_pkg::OP_QUERY, pse_pkg::NUM_W'(4093));

        // --- random ---
        // Each phase: new limit, sometimes a premature query, a build,
        // then mostly in-range queries. Phase 3 sweeps the full store,
        // phase 8 a saturating limit, phase 5 runs with no gaps at all,
        // phase 2 carries the long receiver hold-off.
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            idle_on = (p != 5);
            if (p == 3)
                lim = MAP_DEPTH;
            else if (p == 8)
                lim = $urandom_range(8191, MAP_DEPTH + 1);
            else
                lim = $urandom_range(300, 2);
            write_limit(pse_pkg::LIMIT_W'(lim));
            span = (lim > MAP_DEPTH) ? MAP_DEPTH : lim;

            if ($urandom_range(3) == 0)
                send_word(pse_pkg::OP_QUERY, pse_pkg::NUM_W'($urandom));
            send_word(pse_pkg::OP_BUILD, pse_pkg::NUM_W'($urandom));

            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (p == 2 && k == 20)
                    hold_req = 1'b1;
                roll = $urandom_range(99);
                if (roll < 3 && span <= 300) begin
                    // rebuild over the same limit; small sets only
                    send_word(pse_pkg::OP_BUILD, pse_pkg::NUM_W'($urandom));
                end else begin
                    if (roll < 78)
                        num = $urandom_range(span - 1);
                    else if (roll < 90)
                        num = $urandom_range(4095);
                    else
                        num = span - 1 + $urandom_range(2);   // around the limit
                    if (num > 4095)
                        num = 4095;
                    send_word(pse_pkg::OP_QUERY, pse_pkg::NUM_W'(num));
                end
            end
        end

        wait_idle();
        run_end = 1'b1;
        // let any stray word surface before the verdict
        repeat (20) @(posedge clk);
        if (chk_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
